// File: rtl/css_pkg.sv
package css_pkg;

  // Delimiter style codes
  localparam logic [1:0] STYLE_XML  = 2'd0;
  localparam logic [1:0] STYLE_DASH = 2'd1;
  localparam logic [1:0] STYLE_C    = 2'd2;

  // Delimiter characters
  localparam logic [7:0] CH_LT    = 8'h3C;  // <
  localparam logic [7:0] CH_BANG  = 8'h21;  // !
  localparam logic [7:0] CH_DASH  = 8'h2D;  // -
  localparam logic [7:0] CH_GT    = 8'h3E;  // >
  localparam logic [7:0] CH_SLASH = 8'h2F;  // /
  localparam logic [7:0] CH_STAR  = 8'h2A;  // *

  // Work for one input item: a prefix of up to four text bytes, then an
  // optional segment marker.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            marker;
  } css_entry_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic       valid;
    css_entry_t entry;
  } css_head_t;

endpackage

// File: rtl/comment_splicer_stream.sv
// Path: a byte's work entry is registered in the work queue, then each result in the output register.
// Throughput: one byte accepted per cycle while the 4-entry work queue has room; results
// leave one per cycle while the master side takes them, so a byte with many results holds the result port.
// Reset (rst, synchronous, active high): style returns to XML, the block leaves any comment,
// drops held bytes and the close window, and empties the work queue and output register.
module comment_splicer_stream #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  // Configuration: comment_style
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  // Input items
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // final_byte
  // Result items
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] has_byte, [1] segment_end
  output logic       m_tlast    // run_last
);
  import css_pkg::*;

  logic       accept;
  logic       push;
  css_entry_t push_entry;
  logic       pop;
  logic       full;
  css_head_t  head;

  // Accept whenever the queue has room for this item's work
  assign s_tready = !full;
  assign accept = s_tvalid && s_tready;

  // Front: classify each byte against the delimiters, track comment state,
  // and queue the text bytes and marker it releases
  css_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .in_byte    (s_tdata),
    .in_final   (s_tlast),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue: decouple byte intake from result delivery
  css_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head       (head)
  );

  // Back: walk each queued entry one result per cycle, while the output is not stalled, into the output register
  css_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: rtl/css_front.sv
module css_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  input  logic               in_final,
  output logic               push,
  output css_pkg::css_entry_t push_entry
);
  import css_pkg::*;

  logic [1:0]      style;
  logic            in_comment;
  logic [2:0][7:0] held;
  logic [1:0]      held_count;
  logic [1:0][7:0] close_window;
  logic [1:0]      close_fill;
  logic            segment_nonempty;

  logic [2:0][7:0] held_next;
  logic [1:0]      held_count_next;
  logic            in_comment_next;
  logic [1:0][7:0] close_window_next;
  logic [1:0]      close_fill_next;
  logic            segment_nonempty_next;

  logic [3:0][7:0] cand;
  logic [3:0][7:0] tail;
  logic [2:0]      cn;
  logic [2:0]      olen;
  logic [1:0]      keep;
  logic            open_hit;
  logic            close_hit;
  logic [2:0]      emit;
  logic [2:0]      start;
  logic            work;

  // Queue work only for an item that is actually taken
  assign push = accept && work;

  // Candidate sequence: held bytes followed by the new byte
  always_comb begin
    cand[0] = (held_count == 2'd0) ? in_byte : held[0];
    cand[1] = (held_count == 2'd1) ? in_byte : ((held_count > 2'd1) ? held[1] : 8'h00);
    cand[2] = (held_count == 2'd2) ? in_byte : ((held_count == 2'd3) ? held[2] : 8'h00);
    cand[3] = (held_count == 2'd3) ? in_byte : 8'h00;
    cn = {1'b0, held_count} + 3'd1;
    // tail[j] is the j-th byte counted back from the newest one
    for (int j = 0; j < 4; j++) begin
      tail[j] = cand[2'(held_count - 2'(j))];
    end
  end

  // Delimiter matching per style
  always_comb begin
    case (style)
      STYLE_DASH: begin
        olen = 3'd2;
        open_hit = (held_count >= 2'd1) && (tail[1] == CH_DASH) && (tail[0] == CH_DASH);
        keep = (tail[0] == CH_DASH) ? 2'd1 : 2'd0;
        close_hit = (close_fill >= 2'd1) && (close_window[1] == CH_DASH) &&
                    (in_byte == CH_DASH);
      end
      STYLE_C: begin
        olen = 3'd2;
        open_hit = (held_count >= 2'd1) && (tail[1] == CH_SLASH) && (tail[0] == CH_STAR);
        keep = (tail[0] == CH_SLASH) ? 2'd1 : 2'd0;
        close_hit = (close_fill >= 2'd1) && (close_window[1] == CH_STAR) &&
                    (in_byte == CH_SLASH);
      end
      default: begin
        olen = 3'd4;
        open_hit = (held_count == 2'd3) && (tail[3] == CH_LT) && (tail[2] == CH_BANG) &&
                   (tail[1] == CH_DASH) && (tail[0] == CH_DASH);
        if ((held_count >= 2'd2) && (tail[2] == CH_LT) && (tail[1] == CH_BANG) &&
            (tail[0] == CH_DASH)) begin
          keep = 2'd3;
        end else if ((held_count >= 2'd1) && (tail[1] == CH_LT) && (tail[0] == CH_BANG)) begin
          keep = 2'd2;
        end else if (tail[0] == CH_LT) begin
          keep = 2'd1;
        end else begin
          keep = 2'd0;
        end
        close_hit = (close_fill >= 2'd2) && (close_window[0] == CH_DASH) &&
                    (close_window[1] == CH_DASH) && (in_byte == CH_GT);
      end
    endcase
  end

  // Next state and the work entry for this item
  always_comb begin
    emit = cn - {1'b0, keep};
    start = emit;
    held_next = held;
    held_count_next = held_count;
    in_comment_next = in_comment;
    close_window_next = close_window;
    close_fill_next = close_fill;
    segment_nonempty_next = segment_nonempty;
    push_entry.bytes = cand;
    push_entry.nbytes = 3'd0;
    push_entry.marker = 1'b0;
    work = 1'b0;

    if (in_comment) begin
      if (close_hit) begin
        in_comment_next = 1'b0;
        held_count_next = 2'd0;
        segment_nonempty_next = 1'b0;
        close_fill_next = 2'd0;
      end else begin
        close_window_next[0] = close_window[1];
        close_window_next[1] = in_byte;
        if (close_fill < 2'd2) begin
          close_fill_next = close_fill + 2'd1;
        end
      end
    end else if (open_hit) begin
      // Release text before the open delimiter and close the segment
      push_entry.nbytes = cn - olen;
      push_entry.marker = 1'b1;
      work = 1'b1;
      in_comment_next = 1'b1;
      held_count_next = 2'd0;
      close_fill_next = 2'd0;
      segment_nonempty_next = 1'b0;
    end else if (in_final) begin
      // Flush everything; the segment is nonempty by construction
      push_entry.nbytes = cn;
      push_entry.marker = 1'b1;
      work = 1'b1;
    end else begin
      push_entry.nbytes = emit;
      work = (emit != 3'd0);
      for (int i = 0; i < 3; i++) begin
        held_next[i] = cand[2'(start + 3'(i))];
      end
      held_count_next = keep;
      segment_nonempty_next = segment_nonempty | (emit != 3'd0);
    end

    if (in_final) begin
      in_comment_next = 1'b0;
      held_count_next = 2'd0;
      close_fill_next = 2'd0;
      segment_nonempty_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      style <= STYLE_XML;
      in_comment <= 1'b0;
      held_count <= 2'd0;
      close_fill <= 2'd0;
      segment_nonempty <= 1'b0;
    end else begin
      if (cfg_we) begin
        style <= cfg_data;
      end
      if (accept) begin
        in_comment <= in_comment_next;
        held_count <= held_count_next;
        close_fill <= close_fill_next;
        segment_nonempty <= segment_nonempty_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
      close_window <= close_window_next;
    end
  end

endmodule

// File: rtl/css_queue.sv
module css_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  css_pkg::css_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output css_pkg::css_head_t  head
);
  import css_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  css_entry_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// File: rtl/css_back.sv
module css_back (
  input  logic               clk,
  input  logic               rst,
  input  css_pkg::css_head_t head,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,
  output logic [1:0]         m_tuser,
  output logic               m_tlast
);
  import css_pkg::*;

  logic [2:0] pos;
  logic [2:0] total;
  logic       issue;
  logic       is_byte;
  logic       last;

  assign total = head.entry.nbytes + {2'b00, head.entry.marker};
  assign issue = head.valid && (!m_tvalid || m_tready);
  assign is_byte = (pos < head.entry.nbytes);
  assign last = (pos == total - 3'd1);
  assign pop = issue && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 3'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (issue) begin
        m_tvalid <= 1'b1;
        pos <= last ? 3'd0 : pos + 3'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      m_tdata <= is_byte ? head.entry.bytes[pos[1:0]] : 8'h00;
      m_tuser <= {!is_byte, is_byte};
      m_tlast <= last;
    end
  end

endmodule
